// ===== design/indexed_list_insert_remove_core_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ILIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ILIR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, command/status codes and the cell control bundle.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int DATA_W_DEF = 32;
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    // positions and counts inside the core; covers DEPTH up to 4096 plus one
    localparam int POS_W      = 13;
    // leaves per first-level group of the read tree
    localparam int RD_GRP     = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_INSERT     = 3'd1,
        CELL_FILL       = 3'd2,
        CELL_WRITE      = 3'd3,
        CELL_SHIFT_DOWN = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cnt;
    } t_cell_ctrl;

endpackage

// ===== design/indexed_list_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// Indexed list insert/remove core
// Fixed-capacity positional list built as a row of entry cells.
//
//   channel   direction  handshake           payload
//   command   in         start & !busy       i_cmd, i_index, i_value
//   result    out        o_valid (1 cycle)   o_read_data, o_count, o_empty_res,
//                                            o_status
//
// Each transaction runs through these steps before the next can be accepted:
// the command is registered, all cells shift or load in parallel, the
// second level of the read OR tree is passed, and the result strobe is
// shown. Reset empties the list; entries are not cleared.
// The result cannot be stalled; busy stays high until it has been shown.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_core_assert.svh"

module indexed_list_insert_remove_core
    import ilir_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [VAL_W-1:0]    i_value,
    output logic                o_valid,
    output logic [VAL_W-1:0]    o_read_data,
    output logic [CNT_W-1:0]    o_count,
    output logic                o_empty_res,
    output logic [STATUS_W-1:0] o_status
);

    localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_GATHER = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [CNT_W-1:0]      r_count;
    t_status               r_status;
    logic                  r_rd_ok;

    t_cell_ctrl            ctrl;
    t_status               d_status;
    logic [POS_W-1:0]      d_count;
    logic [POS_W-1:0]      cur_n;
    logic [POS_W-1:0]      cur_p;
    logic                  in_range;
    logic                  do_ins;
    logic                  accept;
    logic [63:0]           val_ext;
    logic [63:0]           rd_ext;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_sel  [DEPTH];
    logic [DATA_WIDTH-1:0] tree_data;

    assign accept  = start && !busy;
    assign val_ext = 64'(i_value);

    // ---------------- command decode ----------------
    assign cur_n    = POS_W'(r_count);
    assign cur_p    = POS_W'(r_pos);
    assign in_range = (cur_p < cur_n);
    assign do_ins   = (r_cmd == CMD_INSERT) || (r_cmd == CMD_REPLACE && !in_range);

    always_comb begin
        ctrl.pos = cur_p;
        ctrl.cnt = cur_n;
        ctrl.op  = CELL_HOLD;
        d_status = ST_OK;
        d_count  = cur_n;
        case (r_cmd)
            CMD_READ: begin
                if (!in_range) begin
                    d_status = ST_BAD_INDEX;
                end
            end
            CMD_REPLACE: begin
                if (in_range) begin
                    ctrl.op = CELL_WRITE;
                end
            end
            CMD_REMOVE: begin
                if (in_range) begin
                    ctrl.op = CELL_SHIFT_DOWN;
                    d_count = cur_n - 1'b1;
                end else begin
                    d_status = ST_BAD_INDEX;
                end
            end
            default: begin
                ctrl.op = CELL_HOLD;
            end
        endcase
        if (do_ins) begin
            if (cur_p <= cur_n) begin
                if (cur_n + 1'b1 > DEPTH_P) begin
                    d_status = ST_FULL;
                end else begin
                    ctrl.op = CELL_INSERT;
                    d_count = cur_n + 1'b1;
                end
            end else if (cur_p + 1'b1 > DEPTH_P) begin
                d_status = ST_FULL;
            end else begin
                ctrl.op = CELL_FILL;
                d_count = cur_p + 1'b1;
            end
        end
        if (r_state != S_EXEC) begin
            ctrl.op = CELL_HOLD;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        case (r_state)
            S_IDLE:   n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:   n_state = S_GATHER;
            S_GATHER: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= d_count[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_pos   <= i_index;
            r_value <= val_ext[DATA_WIDTH-1:0];
        end
        if (r_state == S_EXEC) begin
            r_status <= d_status;
            r_rd_ok  <= (r_cmd == CMD_READ) && in_range;
        end
    end

    // ---------------- cell row ----------------
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (gi == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = cell_data[gi+1];
        end

        ilir_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_value    (r_value),
            .i_left     (left_data),
            .i_right    (right_data),
            .o_data     (cell_data[gi]),
            .o_sel_data (cell_sel[gi])
        );
    end

    ilir_read_tree #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_read_tree (
        .i_clk  (i_clk),
        .i_leaf (cell_sel),
        .o_data (tree_data)
    );

    // ---------------- result ----------------
    assign rd_ext      = 64'(tree_data);
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_RESP);
    assign o_read_data = r_rd_ok ? rd_ext[VAL_W-1:0] : '0;
    assign o_count     = r_count;
    assign o_empty_res = (r_count == '0);
    assign o_status    = r_status;

    // ---------------- checks ----------------
    `ILIR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `ILIR_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `ILIR_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, POS_W'(r_count) <= DEPTH_P)
    `ILIR_ASSERT_NOW(a_bad_read_zero, i_clk, i_rst_n, o_valid && r_status != ST_OK, o_read_data == '0)

endmodule

// ===== design/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry; loads the new value, a neighbor's entry or zero.
// ----------------------------------------------------------------------------
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_sel_data
);

    localparam logic [POS_W-1:0] MY_IDX  = POS_W'(CELL_IDX);
    localparam logic [POS_W-1:0] MY_NEXT = POS_W'(CELL_IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  at_pos;

    assign at_pos = (MY_IDX == i_ctrl.pos);

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (at_pos) begin
                    n_data = i_value;
                end else if (MY_IDX > i_ctrl.pos && MY_IDX <= i_ctrl.cnt) begin
                    n_data = i_left;
                end
            end
            CELL_FILL: begin
                if (at_pos) begin
                    n_data = i_value;
                end else if (MY_IDX >= i_ctrl.cnt && MY_IDX < i_ctrl.pos) begin
                    n_data = '0;
                end
            end
            CELL_WRITE: begin
                if (at_pos) begin
                    n_data = i_value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= i_ctrl.pos && MY_NEXT < i_ctrl.cnt) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_sel_data = at_pos ? r_data : '0;

endmodule

// ===== design/ilir_read_tree.sv =====
// ----------------------------------------------------------------------------
// Indexed list read tree
// Two-level registered OR over the selected cell outputs.
// ----------------------------------------------------------------------------
module ilir_read_tree
    import ilir_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_leaf [DEPTH],
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam int NGRP = (DEPTH + RD_GRP - 1) / RD_GRP;

    logic [DATA_WIDTH-1:0] r_grp [NGRP];
    logic [DATA_WIDTH-1:0] n_grp [NGRP];
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < RD_GRP; k++) begin
                if (g * RD_GRP + k < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_leaf[g * RD_GRP + k];
                end
            end
        end
    end

    always_comb begin
        n_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_data = n_data | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Indexed list core testbench
// A directed table covers reset, the zero fill, the full list and the bad
// index cases. Random commands follow and drive the count between empty
// and full. Every result is checked against its typed-in row or a positional list predictor.
// ----------------------------------------------------------------------------
module tb_top
    import ilir_pkg::*;
();

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int RAND_ITEMS  = 1600;
    localparam int IDLE_LIMIT  = 500;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        logic [VAL_W-1:0] read_data;
        logic [CNT_W-1:0] count;
        logic             empty_res;
        t_status          status;
    } t_list_result;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic             known;   // result typed in below, else predicted
        t_list_result     res;
    } t_cmd_row;

    localparam t_list_result PREDICTED = '{32'h0, 9'd0, 1'b0, ST_OK};

    localparam t_cmd_row DIRECTED [N_DIRECTED] = '{
        '{CMD_READ,    8'd0,   32'h0,        1'b1, '{32'h0, 9'd0, 1'b1, ST_BAD_INDEX}},
        '{CMD_REMOVE,  8'd0,   32'h0,        1'b1, '{32'h0, 9'd0, 1'b1, ST_BAD_INDEX}},
        '{CMD_REPLACE, 8'd0,   32'hFFFFFFFF, 1'b1, '{32'h0, 9'd1, 1'b0, ST_OK}},
        '{CMD_READ,    8'd0,   32'h0,        1'b1, '{32'hFFFFFFFF, 9'd1, 1'b0, ST_OK}},
        '{CMD_INSERT,  8'd0,   32'h0,        1'b0, PREDICTED},
        '{CMD_INSERT,  8'd1,   32'hA5A5A5A5, 1'b0, PREDICTED},
        '{CMD_READ,    8'd2,   32'h0,        1'b0, PREDICTED},
        // insert past the end pads the gap with zeros
        '{CMD_INSERT,  8'd5,   32'h12345678, 1'b0, PREDICTED},
        '{CMD_READ,    8'd3,   32'h0,        1'b0, PREDICTED},
        '{CMD_REMOVE,  8'd1,   32'h0,        1'b0, PREDICTED},
        '{CMD_READ,    8'd255, 32'h0,        1'b1, '{32'h0, 9'd5, 1'b0, ST_BAD_INDEX}},
        '{CMD_REMOVE,  8'd4,   32'h0,        1'b0, PREDICTED},
        '{CMD_INSERT,  8'd255, 32'h80000001, 1'b1, '{32'h0, 9'd256, 1'b0, ST_OK}},
        '{CMD_READ,    8'd255, 32'h0,        1'b1, '{32'h80000001, 9'd256, 1'b0, ST_OK}},
        '{CMD_READ,    8'd254, 32'h0,        1'b1, '{32'h0, 9'd256, 1'b0, ST_OK}},
        '{CMD_INSERT,  8'd0,   32'hDEADBEEF, 1'b1, '{32'h0, 9'd256, 1'b0, ST_FULL}},
        '{CMD_REPLACE, 8'd128, 32'hDEADBEEF, 1'b1, '{32'h0, 9'd256, 1'b0, ST_OK}},
        '{CMD_REMOVE,  8'd255, 32'h0,        1'b1, '{32'h0, 9'd255, 1'b0, ST_OK}},
        // replace at the end turns into an insert
        '{CMD_REPLACE, 8'd255, 32'h7FFFFFFF, 1'b1, '{32'h0, 9'd256, 1'b0, ST_OK}},
        '{CMD_INSERT,  8'd128, 32'h0,        1'b1, '{32'h0, 9'd256, 1'b0, ST_FULL}},
        '{CMD_READ,    8'd128, 32'h0,        1'b0, PREDICTED},
        '{CMD_REMOVE,  8'd0,   32'h0,        1'b0, PREDICTED},
        '{CMD_READ,    8'd0,   32'h0,        1'b0, PREDICTED},
        '{CMD_INSERT,  8'd255, 32'h55555555, 1'b0, PREDICTED},
        '{CMD_REMOVE,  8'd3,   32'h0,        1'b0, PREDICTED}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [IDX_W-1:0]    i_index;
    logic [VAL_W-1:0]    i_value;
    logic                o_valid;
    logic [VAL_W-1:0]    o_read_data;
    logic [CNT_W-1:0]    o_count;
    logic                o_empty_res;
    logic [STATUS_W-1:0] o_status;

    indexed_list_insert_remove_core #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (DATA_W_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_read_data (o_read_data),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // list contents as the block should hold them
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_count = 0;
    t_list_result     expected_q [$];
    int               mismatches = 0;
    int               idle_cycles = 0;

    function automatic t_status list_insert_at(int pos, logic [VAL_W-1:0] val);
        if (pos <= list_count) begin
            if (list_count + 1 > LIST_DEPTH)
                return ST_FULL;
            for (int i = list_count; i > pos; i--)
                list_mem[i] = list_mem[i-1];
            list_mem[pos] = val;
            list_count++;
        end else begin
            if (pos + 1 > LIST_DEPTH)
                return ST_FULL;
            for (int i = list_count; i < pos; i++)
                list_mem[i] = '0;
            list_mem[pos] = val;
            list_count = pos + 1;
        end
        return ST_OK;
    endfunction

    function automatic t_list_result predict_list_op(t_cmd cmd, int pos,
                                                     logic [VAL_W-1:0] val);
        t_list_result r;
        r.read_data = '0;
        r.status    = ST_OK;
        case (cmd)
            CMD_READ: begin
                if (pos < list_count)
                    r.read_data = list_mem[pos];
                else
                    r.status = ST_BAD_INDEX;
            end
            CMD_INSERT: begin
                r.status = list_insert_at(pos, val);
            end
            CMD_REPLACE: begin
                if (pos < list_count)
                    list_mem[pos] = val;
                else
                    r.status = list_insert_at(pos, val);
            end
            default: begin
                if (pos < list_count) begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
        endcase
        r.count     = list_count[CNT_W-1:0];
        r.empty_res = (list_count == 0);
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue_cmd(t_cmd cmd, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic known, t_list_result known_res);
        t_list_result pred;
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = predict_list_op(cmd, idx, val);
        expected_q.push_back(known ? known_res : pred);
    endtask

    task automatic note_mismatch(bit stray, t_list_result want, t_list_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (stray)
                $display("result with no command pending: data=%h count=%0d %s%b status=%0d",
                         got.read_data, got.count, "empty=", got.empty_res, got.status);
            else
                $display({"mismatch: exp data=%h count=%0d empty=%b status=%0d",
                          " / got data=%h count=%0d empty=%b status=%0d"},
                         want.read_data, want.count, want.empty_res, want.status,
                         got.read_data, got.count, got.empty_res, got.status);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            got = '{o_read_data, o_count, o_empty_res, t_status'(o_status)};
            if (expected_q.size() == 0) begin
                note_mismatch(1'b1, PREDICTED, got);
            end else begin
                want = expected_q.pop_front();
                if (o_valid !== 1'b1 ||
                    got.read_data !== want.read_data ||
                    got.count     !== want.count ||
                    got.empty_res !== want.empty_res ||
                    got.status    !== want.status)
                    note_mismatch(1'b0, want, got);
            end
        end
    end

    // watchdog: too long without a transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** indexed_list_insert_remove_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int               target;
        int               r;
        int               hi;
        bit               calm;
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= CMD_READ;
        i_index <= '0;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            idle_gap(pick_gap(1'b0));
            issue_cmd(DIRECTED[k].cmd, DIRECTED[k].index, DIRECTED[k].value,
                      DIRECTED[k].known, DIRECTED[k].res);
        end

        // count walks toward a moving target: empty, full or somewhere between
        target = 0;
        calm   = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (list_count == target) begin
                r = $urandom_range(0, 3);
                target = (r == 0) ? 0 : (r == 1) ? LIST_DEPTH : $urandom_range(0, LIST_DEPTH);
            end
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);

            r = $urandom_range(0, 99);
            if (r < 60)
                cmd = (list_count < target) ? CMD_INSERT : CMD_REMOVE;
            else if (r < 72)
                cmd = (list_count < target) ? CMD_REMOVE : CMD_INSERT;
            else if (r < 86)
                cmd = CMD_READ;
            else
                cmd = CMD_REPLACE;

            hi = (list_count > 255) ? 255 : list_count;
            r  = $urandom_range(0, 99);
            if (r < 70)
                idx = IDX_W'($urandom_range(0, hi));
            else if (r < 85)
                idx = (list_count + 3 > 255) ? 8'd255 :
                      IDX_W'(list_count + $urandom_range(0, 3));
            else
                idx = IDX_W'($urandom_range(0, 255));

            r = $urandom_range(0, 9);
            val = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;

            idle_gap(pick_gap(calm));
            issue_cmd(cmd, idx, val, 1'b0, PREDICTED);
        end
        start <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("** indexed_list_insert_remove_core: PASSED **");
        else
            $display("** indexed_list_insert_remove_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ilir_pkg.sv
design/ilir_cell.sv
design/ilir_read_tree.sv
design/indexed_list_insert_remove_core.sv
verif/tb_top.sv
